// ===== rtl/ille_pkg.sv =====
// Shared types and codes for the indexed linked list engine.
// Depends on nothing; used by ille_ctrl, ille_dp and indexed_linked_list_engine.
package ille_pkg;

	// Request operation codes.
	typedef enum logic [3:0] {
		OP_PUSH_TAIL = 4'd0,
		OP_PUSH_HEAD = 4'd1,
		OP_POP_HEAD  = 4'd2,
		OP_PEEK_HEAD = 4'd3,
		OP_READ      = 4'd4,
		OP_INSERT    = 4'd5,
		OP_REMOVE    = 4'd6,
		OP_SWAP      = 4'd7,
		OP_TRUNCATE  = 4'd8
	} op_e;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2
	} stat_e;

	// Datapath commands issued by the controller.
	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_ALLOC_RD,
		CMD_ALLOC_TAKE,
		CMD_NEW_TAIL,
		CMD_LINK_TAIL,
		CMD_NEW_HEAD,
		CMD_LINK_HEAD,
		CMD_SEL_HEAD,
		CMD_SEL_TAIL,
		CMD_RD_PAY,
		CMD_WALK_INIT,
		CMD_WALK_RD,
		CMD_WALK_ADV,
		CMD_UNL_RD,
		CMD_UNL_LINK,
		CMD_UNL_FREE,
		CMD_INS_RD,
		CMD_INS_NEW,
		CMD_INS_LINK,
		CMD_SAVE_A,
		CMD_SWAP_B,
		CMD_SWAP_A,
		CMD_FINISH
	} cmd_e;

	typedef struct packed {
		cmd_e  code;
		logic  alt;     // walk toward the second position
		stat_e status;  // status of the finished word
		logic  keep;    // result carries the payload that was read
	} cmd_t;

	typedef struct packed {
		op_e  op;
		logic empty;
		logic full;
		logic pos_bad;
		logic pos2_bad;
		logic walk_done;
		logic trunc_more;
	} sts_t;

	typedef struct packed {
		logic [3:0]  operation;
		logic [6:0]  position;
		logic [5:0]  other_position;
		logic [31:0] payload;
	} in_t;

	typedef struct packed {
		logic [31:0] payload_out;
		logic [1:0]  status;
		logic [6:0]  item_count;
	} out_t;

endpackage

// ===== rtl/ille_ctrl.sv =====
// Controller state machine of the indexed linked list engine.
// Depends on ille_pkg; drives ille_dp through cmd_t and reads sts_t.
module ille_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  ille_pkg::sts_t sts,
	output ille_pkg::cmd_t cmd
);
	import ille_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_PUSH_ARD, S_PUSH_TAKE, S_PUSH_NEW, S_PUSH_LINK,
		S_HEAD_SEL, S_RD_PAY, S_WALK_INIT, S_WALK_RD, S_WALK_ADV,
		S_UNL_RD, S_UNL_LINK, S_UNL_FREE, S_INS_RD, S_INS_ARD, S_INS_TAKE,
		S_INS_NEW, S_INS_LINK, S_SAVE_A, S_SWAP_B, S_SWAP_A,
		S_TR_CHECK, S_TR_SEL, S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   second_q, second_d;
	stat_e  st_q, st_d;
	logic   keep_q, keep_d;
	logic   ovalid_q;
	logic   fin_load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
	assign fin_load  = (state_q == S_FIN) && (!ovalid_q || out_ready);

	// Next state and command decode.
	always_comb begin
		state_d    = state_q;
		second_d   = second_q;
		st_d       = st_q;
		keep_d     = keep_q;
		cmd        = '0;
		cmd.code   = CMD_NOP;
		cmd.alt    = second_q;
		cmd.status = st_q;
		cmd.keep   = keep_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = CMD_LOAD;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				st_d     = ST_OK;
				keep_d   = 1'b0;
				second_d = 1'b0;
				case (sts.op)
					OP_PUSH_TAIL, OP_PUSH_HEAD: begin
						if (sts.full) begin
							st_d = ST_FULL;
							state_d = S_FIN;
						end else begin
							state_d = S_PUSH_ARD;
						end
					end
					OP_POP_HEAD, OP_PEEK_HEAD: begin
						if (sts.empty) begin
							st_d = ST_BAD;
							state_d = S_FIN;
						end else begin
							state_d = S_HEAD_SEL;
						end
					end
					OP_READ, OP_REMOVE: begin
						if (sts.pos_bad) begin
							st_d = ST_BAD;
							state_d = S_FIN;
						end else begin
							state_d = S_WALK_INIT;
						end
					end
					OP_INSERT: begin
						if (sts.pos_bad) begin
							st_d = ST_BAD;
							state_d = S_FIN;
						end else if (sts.full) begin
							st_d = ST_FULL;
							state_d = S_FIN;
						end else begin
							state_d = S_WALK_INIT;
						end
					end
					OP_SWAP: begin
						if (sts.pos_bad || sts.pos2_bad) begin
							st_d = ST_BAD;
							state_d = S_FIN;
						end else begin
							state_d = S_WALK_INIT;
						end
					end
					OP_TRUNCATE: state_d = S_TR_CHECK;
					default: begin
						st_d = ST_BAD;
						state_d = S_FIN;
					end
				endcase
			end
			S_PUSH_ARD: begin
				cmd.code = CMD_ALLOC_RD;
				state_d  = S_PUSH_TAKE;
			end
			S_PUSH_TAKE: begin
				cmd.code = CMD_ALLOC_TAKE;
				state_d  = S_PUSH_NEW;
			end
			S_PUSH_NEW: begin
				cmd.code = (sts.op == OP_PUSH_TAIL) ? CMD_NEW_TAIL : CMD_NEW_HEAD;
				state_d  = S_PUSH_LINK;
			end
			S_PUSH_LINK: begin
				cmd.code = (sts.op == OP_PUSH_TAIL) ? CMD_LINK_TAIL : CMD_LINK_HEAD;
				state_d  = S_FIN;
			end
			S_HEAD_SEL: begin
				cmd.code = CMD_SEL_HEAD;
				state_d  = S_RD_PAY;
			end
			S_WALK_INIT: begin
				cmd.code = CMD_WALK_INIT;
				state_d  = S_WALK_RD;
			end
			S_WALK_RD: begin
				if (sts.walk_done) begin
					state_d = (sts.op == OP_INSERT) ? S_INS_RD : S_RD_PAY;
				end else begin
					cmd.code = CMD_WALK_RD;
					state_d  = S_WALK_ADV;
				end
			end
			S_WALK_ADV: begin
				cmd.code = CMD_WALK_ADV;
				state_d  = S_WALK_RD;
			end
			S_RD_PAY: begin
				cmd.code = CMD_RD_PAY;
				case (sts.op)
					OP_POP_HEAD, OP_REMOVE: begin
						keep_d  = 1'b1;
						state_d = S_UNL_RD;
					end
					OP_SWAP: state_d = second_q ? S_SWAP_B : S_SAVE_A;
					default: begin
						keep_d  = 1'b1;
						state_d = S_FIN;
					end
				endcase
			end
			S_SAVE_A: begin
				cmd.code = CMD_SAVE_A;
				second_d = 1'b1;
				state_d  = S_WALK_INIT;
			end
			S_SWAP_B: begin
				cmd.code = CMD_SWAP_B;
				state_d  = S_SWAP_A;
			end
			S_SWAP_A: begin
				cmd.code = CMD_SWAP_A;
				state_d  = S_FIN;
			end
			S_UNL_RD: begin
				cmd.code = CMD_UNL_RD;
				state_d  = S_UNL_LINK;
			end
			S_UNL_LINK: begin
				cmd.code = CMD_UNL_LINK;
				state_d  = S_UNL_FREE;
			end
			S_UNL_FREE: begin
				cmd.code = CMD_UNL_FREE;
				state_d  = (sts.op == OP_TRUNCATE) ? S_TR_CHECK : S_FIN;
			end
			S_TR_CHECK: begin
				state_d = sts.trunc_more ? S_TR_SEL : S_FIN;
			end
			S_TR_SEL: begin
				cmd.code = CMD_SEL_TAIL;
				state_d  = S_UNL_RD;
			end
			S_INS_RD: begin
				cmd.code = CMD_INS_RD;
				state_d  = S_INS_ARD;
			end
			S_INS_ARD: begin
				cmd.code = CMD_ALLOC_RD;
				state_d  = S_INS_TAKE;
			end
			S_INS_TAKE: begin
				cmd.code = CMD_ALLOC_TAKE;
				state_d  = S_INS_NEW;
			end
			S_INS_NEW: begin
				cmd.code = CMD_INS_NEW;
				state_d  = S_INS_LINK;
			end
			S_INS_LINK: begin
				cmd.code = CMD_INS_LINK;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (fin_load) begin
					cmd.code = CMD_FINISH;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			second_q <= 1'b0;
			st_q     <= ST_OK;
			keep_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
			st_q     <= st_d;
			keep_q   <= keep_d;
			if (fin_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/ille_dp.sv =====
// Datapath of the indexed linked list engine: node memories, list pointers,
// walk counter and the result word. Depends on ille_pkg; driven by ille_ctrl.
module ille_dp #(
	parameter int POOL_DEPTH   = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ille_pkg::in_t  req,
	input  ille_pkg::cmd_t cmd,
	output ille_pkg::sts_t sts,
	output ille_pkg::out_t res
);
	import ille_pkg::*;

	localparam int AW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int NW   = $clog2(POOL_DEPTH + 1);
	localparam int CMPW = (NW > 7) ? NW : 7;
	localparam logic [NW-1:0] NULL_NODE = NW'(POOL_DEPTH);

	// Node memories.
	logic [PAYLOAD_BITS-1:0] pay_mem [POOL_DEPTH];
	logic [NW-1:0]           nxt_mem [POOL_DEPTH];
	logic [NW-1:0]           prv_mem [POOL_DEPTH];

	logic                    pay_we, pay_re, nxt_we, nxt_re, prv_we, prv_re;
	logic [NW-1:0]           pay_wa, pay_ra, nxt_wa, nxt_ra, prv_wa, prv_ra;
	logic [PAYLOAD_BITS-1:0] pay_wd, pay_rd_q;
	logic [NW-1:0]           nxt_wd, nxt_rd_q, prv_wd, prv_rd_q;

	// List pointers and request registers.
	logic [NW-1:0]           head_q, tail_q, fhead_q, wmark_q, items_q;
	logic [NW-1:0]           cur_q, new_q, a_q;
	logic [6:0]              cnt_q, tgt_q;
	op_e                     op_q;
	logic [6:0]              pos_q;
	logic [5:0]              pos2_q;
	logic [PAYLOAD_BITS-1:0] data_q, tmp_q;
	out_t                    res_q;
	logic [63:0]             in_ext, pay_ext;

	function automatic logic is_node(input logic [NW-1:0] n);
		return n < NULL_NODE;
	endfunction

	assign in_ext  = {32'd0, req.payload};
	assign pay_ext = 64'(pay_rd_q);
	assign res     = res_q;

	// Status words toward the controller.
	always_comb begin
		sts.op         = op_q;
		sts.empty      = (items_q == '0);
		sts.full       = (items_q >= NULL_NODE);
		sts.pos_bad    = CMPW'(pos_q) >= CMPW'(items_q);
		sts.pos2_bad   = CMPW'(pos2_q) >= CMPW'(items_q);
		sts.walk_done  = (cnt_q == tgt_q);
		sts.trunc_more = CMPW'(items_q) > CMPW'(pos_q);
	end

	// Memory port selection per command.
	always_comb begin
		pay_we = 1'b0; pay_wa = cur_q; pay_wd = data_q;
		pay_re = 1'b0; pay_ra = cur_q;
		nxt_we = 1'b0; nxt_wa = cur_q; nxt_wd = NULL_NODE;
		nxt_re = 1'b0; nxt_ra = cur_q;
		prv_we = 1'b0; prv_wa = cur_q; prv_wd = NULL_NODE;
		prv_re = 1'b0; prv_ra = cur_q;
		case (cmd.code)
			CMD_ALLOC_RD: begin
				nxt_re = is_node(fhead_q);
				nxt_ra = fhead_q;
			end
			CMD_NEW_TAIL: begin
				pay_we = 1'b1; pay_wa = new_q;
				prv_we = 1'b1; prv_wa = new_q; prv_wd = tail_q;
				nxt_we = 1'b1; nxt_wa = new_q; nxt_wd = NULL_NODE;
			end
			CMD_LINK_TAIL: begin
				nxt_we = is_node(tail_q); nxt_wa = tail_q; nxt_wd = new_q;
			end
			CMD_NEW_HEAD: begin
				pay_we = 1'b1; pay_wa = new_q;
				prv_we = 1'b1; prv_wa = new_q; prv_wd = NULL_NODE;
				nxt_we = 1'b1; nxt_wa = new_q; nxt_wd = head_q;
			end
			CMD_LINK_HEAD: begin
				prv_we = is_node(head_q); prv_wa = head_q; prv_wd = new_q;
			end
			CMD_RD_PAY: pay_re = 1'b1;
			CMD_WALK_RD: nxt_re = 1'b1;
			CMD_UNL_RD: begin
				nxt_re = 1'b1;
				prv_re = 1'b1;
			end
			CMD_UNL_LINK: begin
				nxt_we = is_node(prv_rd_q); nxt_wa = prv_rd_q; nxt_wd = nxt_rd_q;
				prv_we = is_node(nxt_rd_q); prv_wa = nxt_rd_q; prv_wd = prv_rd_q;
			end
			CMD_UNL_FREE: begin
				nxt_we = 1'b1; nxt_wa = cur_q; nxt_wd = fhead_q;
			end
			CMD_INS_RD: prv_re = 1'b1;
			CMD_INS_NEW: begin
				pay_we = 1'b1; pay_wa = new_q;
				prv_we = 1'b1; prv_wa = new_q; prv_wd = prv_rd_q;
				nxt_we = 1'b1; nxt_wa = new_q; nxt_wd = cur_q;
			end
			CMD_INS_LINK: begin
				prv_we = 1'b1; prv_wa = cur_q; prv_wd = new_q;
				nxt_we = is_node(prv_rd_q); nxt_wa = prv_rd_q; nxt_wd = new_q;
			end
			CMD_SWAP_B: begin
				pay_we = 1'b1; pay_wa = cur_q; pay_wd = tmp_q;
			end
			CMD_SWAP_A: begin
				pay_we = 1'b1; pay_wa = a_q; pay_wd = pay_rd_q;
			end
			default: ;
		endcase
	end

	// Payload memory.
	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[pay_wa[AW-1:0]] <= pay_wd;
		end
		if (pay_re) begin
			pay_rd_q <= pay_mem[pay_ra[AW-1:0]];
		end
	end

	// Forward link memory.
	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_wa[AW-1:0]] <= nxt_wd;
		end
		if (nxt_re) begin
			nxt_rd_q <= nxt_mem[nxt_ra[AW-1:0]];
		end
	end

	// Backward link memory.
	always_ff @(posedge clk) begin
		if (prv_we) begin
			prv_mem[prv_wa[AW-1:0]] <= prv_wd;
		end
		if (prv_re) begin
			prv_rd_q <= prv_mem[prv_ra[AW-1:0]];
		end
	end

	// Payload-side registers: request, walk node and result word.
	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_LOAD: begin
				pos_q  <= req.position;
				pos2_q <= req.other_position;
				data_q <= in_ext[PAYLOAD_BITS-1:0];
			end
			CMD_SEL_HEAD: cur_q <= head_q;
			CMD_SEL_TAIL: cur_q <= tail_q;
			CMD_WALK_INIT: begin
				cur_q <= head_q;
				tgt_q <= cmd.alt ? {1'b0, pos2_q} : pos_q;
			end
			CMD_WALK_ADV: cur_q <= nxt_rd_q;
			CMD_SAVE_A: begin
				a_q   <= cur_q;
				tmp_q <= pay_rd_q;
			end
			CMD_FINISH: begin
				res_q.payload_out <= cmd.keep ? pay_ext[31:0] : 32'd0;
				res_q.status      <= cmd.status;
				res_q.item_count  <= 7'(items_q);
			end
			default: ;
		endcase
	end

	// List control registers: pointers, allocation and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_PUSH_TAIL;
			head_q  <= NULL_NODE;
			tail_q  <= NULL_NODE;
			fhead_q <= NULL_NODE;
			wmark_q <= '0;
			items_q <= '0;
			new_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (cmd.code)
				CMD_LOAD: op_q <= op_e'(req.operation);
				CMD_ALLOC_TAKE: begin
					if (is_node(fhead_q)) begin
						new_q   <= fhead_q;
						fhead_q <= nxt_rd_q;
					end else begin
						new_q   <= wmark_q;
						wmark_q <= wmark_q + 1'b1;
					end
				end
				CMD_LINK_TAIL: begin
					if (!is_node(tail_q)) begin
						head_q <= new_q;
					end
					tail_q  <= new_q;
					items_q <= items_q + 1'b1;
				end
				CMD_LINK_HEAD: begin
					if (!is_node(head_q)) begin
						tail_q <= new_q;
					end
					head_q  <= new_q;
					items_q <= items_q + 1'b1;
				end
				CMD_WALK_INIT: cnt_q <= '0;
				CMD_WALK_ADV: cnt_q <= cnt_q + 1'b1;
				CMD_UNL_LINK: begin
					if (!is_node(prv_rd_q)) begin
						head_q <= nxt_rd_q;
					end
					if (!is_node(nxt_rd_q)) begin
						tail_q <= prv_rd_q;
					end
				end
				CMD_UNL_FREE: begin
					fhead_q <= cur_q;
					items_q <= items_q - 1'b1;
				end
				CMD_INS_LINK: begin
					if (!is_node(prv_rd_q)) begin
						head_q <= new_q;
					end
					items_q <= items_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/indexed_linked_list_engine.sv =====
// Top level of the indexed linked list engine.
// Depends on ille_pkg, ille_ctrl and ille_dp.
//
// An ordered list of payload words kept in a pool of POOL_DEPTH nodes with
// forward and backward links. Each accepted request word gives exactly one
// result word. Requests are served one at a time. Read, remove, insert and
// swap walk the forward links from the head to the position (swap walks
// twice), and truncate removes items from the tail one by one. Nodes that
// were never used are handed out by a counter, so no clearing pass follows
// reset. A new request is taken while the previous result word still waits
// in the output register.
module indexed_linked_list_engine #(
	parameter int POOL_DEPTH   = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ille_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ille_pkg::out_t out_data
);
	import ille_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	ille_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Node pool and list registers.
	ille_dp #(
		.POOL_DEPTH   (POOL_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (in_data),
		.cmd    (cmd),
		.sts    (sts),
		.res    (out_data)
	);

endmodule

// ===== tb/tb_indexed_linked_list_engine.sv =====
// Testbench for the indexed linked list engine: directed table, pool fill, then random requests.
// Depends on ille_pkg and the indexed_linked_list_engine RTL; needs no files.
module tb_indexed_linked_list_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import ille_pkg::*;

	localparam int DEPTH = 64;
	localparam int NULLN = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	indexed_linked_list_engine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// List state of the predictor.
	logic [31:0] lst_pay [DEPTH];
	int lst_next [DEPTH];
	int lst_prev [DEPTH];
	int lst_head, lst_tail, lst_free, lst_items;

	out_t result_queue[$];
	int mismatches = 0;
	int checked = 0;
	bit quiet = 1'b0;
	int op_seen [16];

	// Directed stimulus; a row with has_exp set also carries a hand-typed result.
	typedef struct {
		in_t req;
		bit has_exp;
		out_t exp;
	} row_t;

	function automatic in_t mk(op_e op, int p, int p2, logic [31:0] d);
		in_t r;
		r.operation = op;
		r.position = p[6:0];
		r.other_position = p2[5:0];
		r.payload = d;
		return r;
	endfunction

	function automatic out_t res(logic [31:0] d, stat_e s, int c);
		out_t r;
		r.payload_out = d;
		r.status = s;
		r.item_count = c[6:0];
		return r;
	endfunction

	function automatic void list_clear();
		for (int i = 0; i < DEPTH; i++) begin
			lst_pay[i] = '0;
			lst_next[i] = i + 1;
			lst_prev[i] = NULLN;
		end
		lst_head = NULLN;
		lst_tail = NULLN;
		lst_free = 0;
		lst_items = 0;
	endfunction

	function automatic int node_of(int p);
		int n;
		n = lst_head;
		for (int i = 0; i < p && n < NULLN; i++)
			n = lst_next[n];
		return n;
	endfunction

	function automatic void unlink(int n);
		int p, x;
		p = lst_prev[n];
		x = lst_next[n];
		if (p < NULLN) lst_next[p] = x; else lst_head = x;
		if (x < NULLN) lst_prev[x] = p; else lst_tail = p;
		if (lst_items > 0) lst_items--;
		lst_next[n] = lst_free;
		lst_prev[n] = NULLN;
		lst_free = n;
	endfunction

	// Apply one request to the predicted list and return the expected result.
	function automatic out_t list_apply(in_t r);
		logic [31:0] pay;
		stat_e st;
		int n, t, a, b, p, p2;
		logic [31:0] tmp;
		pay = '0;
		st = ST_OK;
		p = r.position;
		p2 = r.other_position;
		case (r.operation)
			OP_PUSH_TAIL, OP_PUSH_HEAD: begin
				if (lst_items >= DEPTH || lst_free >= NULLN) begin
					st = ST_FULL;
				end else begin
					n = lst_free;
					lst_free = lst_next[n];
					lst_pay[n] = r.payload;
					if (r.operation == OP_PUSH_TAIL) begin
						lst_prev[n] = lst_tail;
						lst_next[n] = NULLN;
						if (lst_tail < NULLN) lst_next[lst_tail] = n; else lst_head = n;
						lst_tail = n;
					end else begin
						lst_prev[n] = NULLN;
						lst_next[n] = lst_head;
						if (lst_head < NULLN) lst_prev[lst_head] = n; else lst_tail = n;
						lst_head = n;
					end
					lst_items++;
				end
			end
			OP_POP_HEAD, OP_PEEK_HEAD: begin
				if (lst_items == 0 || lst_head >= NULLN) begin
					st = ST_BAD;
				end else begin
					pay = lst_pay[lst_head];
					if (r.operation == OP_POP_HEAD) unlink(lst_head);
				end
			end
			OP_READ, OP_REMOVE: begin
				n = node_of(p);
				if (p >= lst_items || n >= NULLN) begin
					st = ST_BAD;
				end else begin
					pay = lst_pay[n];
					if (r.operation == OP_REMOVE) unlink(n);
				end
			end
			OP_INSERT: begin
				if (p >= lst_items) begin
					st = ST_BAD;
				end else if (lst_items >= DEPTH || lst_free >= NULLN) begin
					st = ST_FULL;
				end else begin
					t = node_of(p);
					n = lst_free;
					lst_free = lst_next[n];
					lst_pay[n] = r.payload;
					lst_prev[n] = lst_prev[t];
					lst_next[n] = t;
					if (lst_prev[t] < NULLN) lst_next[lst_prev[t]] = n; else lst_head = n;
					lst_prev[t] = n;
					lst_items++;
				end
			end
			OP_SWAP: begin
				if (p >= lst_items || p2 >= lst_items) begin
					st = ST_BAD;
				end else begin
					a = node_of(p);
					b = node_of(p2);
					tmp = lst_pay[a];
					lst_pay[a] = lst_pay[b];
					lst_pay[b] = tmp;
				end
			end
			OP_TRUNCATE: begin
				while (lst_items > p && lst_tail < NULLN)
					unlink(lst_tail);
			end
			default: st = ST_BAD;
		endcase
		return res(pay, st, lst_items);
	endfunction

	// Send one request word, honoring the sender's random idle cycles.
	// Valid drops only in idle cycles, so it is assigned once per clock edge.
	task automatic send(in_t r);
		while (!quiet && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		op_seen[r.operation]++;
		result_queue.push_back(list_apply(r));
	endtask

	// Result side: random stalls, and comparison against the oldest expectation.
	always @(posedge clk) begin
		out_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (result_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %p", out_data);
				end else begin
					e = result_queue.pop_front();
					checked++;
					if (out_data.payload_out !== e.payload_out || out_data.status !== e.status
						|| out_data.item_count !== e.item_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", e, out_data);
					end
				end
			end
			out_ready <= quiet || ($urandom_range(99) >= 21);
		end
	end

	// Generous time limit.
	initial begin
		#20ms;
		$display("tb_indexed_linked_list_engine: FAIL");
		$finish;
	end

	// Random request biased toward meaningful positions.
	function automatic in_t rand_req();
		int k, p, p2;
		op_e op;
		k = $urandom_range(99);
		p = (lst_items > 0 && $urandom_range(9) < 8) ? $urandom_range(lst_items - 1)
			: $urandom_range(64);
		p2 = (lst_items > 0 && $urandom_range(9) < 8) ? $urandom_range(lst_items - 1)
			: $urandom_range(63);
		if (k < 2) return mk(op_e'($urandom_range(15, 9)), p, p2, $urandom);
		if (k < 22) op = OP_PUSH_TAIL;
		else if (k < 36) op = OP_PUSH_HEAD;
		else if (k < 44) op = OP_POP_HEAD;
		else if (k < 50) op = OP_PEEK_HEAD;
		else if (k < 62) op = OP_READ;
		else if (k < 74) op = OP_INSERT;
		else if (k < 84) op = OP_REMOVE;
		else if (k < 94) op = OP_SWAP;
		else begin
			op = OP_TRUNCATE;
			p = $urandom_range(64);
		end
		return mk(op, p, p2, $urandom);
	endfunction

	initial begin
		row_t plan[$];
		row_t rw;
		int timeout;
		for (int i = 0; i < 16; i++) op_seen[i] = 0;
		list_clear();
		// Empty list, extremes of the fields, and refusals with their error codes.
		plan.push_back('{mk(OP_POP_HEAD, 0, 0, 0), 1, res(0, ST_BAD, 0)});
		plan.push_back('{mk(OP_PEEK_HEAD, 0, 0, 0), 1, res(0, ST_BAD, 0)});
		plan.push_back('{mk(OP_INSERT, 0, 0, 32'h1), 1, res(0, ST_BAD, 0)});
		plan.push_back('{mk(OP_READ, 127, 63, 0), 1, res(0, ST_BAD, 0)});
		plan.push_back('{mk(OP_SWAP, 0, 0, 0), 1, res(0, ST_BAD, 0)});
		plan.push_back('{mk(OP_TRUNCATE, 0, 0, 0), 1, res(0, ST_OK, 0)});
		plan.push_back('{in_t'({4'd15, 7'd0, 6'd0, 32'd0}), 1, res(0, ST_BAD, 0)});
		plan.push_back('{mk(OP_PUSH_TAIL, 0, 0, 32'hFFFF_FFFF), 1, res(0, ST_OK, 1)});
		plan.push_back('{mk(OP_PUSH_HEAD, 127, 63, 32'h0), 1, res(0, ST_OK, 2)});
		plan.push_back('{mk(OP_PEEK_HEAD, 0, 0, 0), 1, res(0, ST_OK, 2)});
		plan.push_back('{mk(OP_READ, 1, 0, 0), 1, res(32'hFFFF_FFFF, ST_OK, 2)});
		plan.push_back('{mk(OP_READ, 2, 0, 0), 1, res(0, ST_BAD, 2)});
		plan.push_back('{mk(OP_INSERT, 1, 0, 32'hA5A5_5A5A), 0, '0});
		plan.push_back('{mk(OP_SWAP, 0, 2, 0), 0, '0});
		plan.push_back('{mk(OP_SWAP, 1, 1, 0), 0, '0});
		plan.push_back('{mk(OP_SWAP, 0, 63, 0), 1, res(0, ST_BAD, 3)});
		plan.push_back('{mk(OP_REMOVE, 1, 0, 0), 0, '0});
		plan.push_back('{mk(OP_TRUNCATE, 64, 0, 0), 1, res(0, ST_OK, 2)});
		plan.push_back('{mk(OP_POP_HEAD, 0, 0, 0), 0, '0});
		plan.push_back('{mk(OP_TRUNCATE, 0, 0, 0), 1, res(0, ST_OK, 0)});
		for (int i = 0; i < 7; i++) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (plan[i]) begin
			rw = plan[i];
			send(rw.req);
			if (rw.has_exp && result_queue[$] != rw.exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: table expects %p, predictor %p", i, rw.exp, result_queue[$]);
			end
		end

		// Fill the pool to the top, then hit the full refusals and the last position.
		for (int i = 0; i < DEPTH; i++)
			send(mk(i[0] ? OP_PUSH_HEAD : OP_PUSH_TAIL, 0, 0, $urandom));
		send(mk(OP_PUSH_TAIL, 0, 0, $urandom));
		send(mk(OP_INSERT, 63, 0, $urandom));
		send(mk(OP_INSERT, 64, 0, $urandom));
		send(mk(OP_READ, 63, 0, 0));
		send(mk(OP_SWAP, 63, 0, 0));

		// Pause until every result is back.
		in_valid <= 1'b0;
		do @(posedge clk); while (result_queue.size() != 0);

		// Random requests, a stretch of them with no idling on either side.
		for (int i = 0; i < 360; i++) begin
			quiet = (i >= 150 && i < 230);
			send(rand_req());
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		timeout = 0;
		while (result_queue.size() != 0 && timeout < 100000) begin
			@(posedge clk);
			timeout++;
		end
		repeat (300) @(posedge clk);
		$display("Checked %0d result words; final list held %0d items.", checked, lst_items);
		$display("Requests covered all nine operations, invalid codes, empty and full pool.");
		if (mismatches == 0 && result_queue.size() == 0)
			$display("tb_indexed_linked_list_engine: PASS");
		else
			$display("tb_indexed_linked_list_engine: FAIL");
		$finish;
	end
endmodule
